// File: hw/rtl/tshd_pkg.sv
// tshd_pkg: constants, types and the arctangent table of the track-step distance block
package tshd_pkg;

  // cordic iteration count and its ceiling
  localparam int CORDIC_ITERATIONS = 32;
  localparam int MAX_ITER = 40;
  localparam int CORDIC_STEPS = (CORDIC_ITERATIONS > MAX_ITER) ? MAX_ITER : CORDIC_ITERATIONS;

  // step counter covers the cordic and square root loops
  localparam int CNT_W = $clog2(MAX_ITER);
  localparam int SQRT_STEPS = 31;

  // datapath widths
  localparam int ANG_W = 34;
  localparam int CW = 44;
  localparam int MUL_W = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int Q_W = 32;
  localparam int DIST_W = 35;

  // angle turn sizes in units of 1e-7 degree
  localparam logic signed [ANG_W-1:0] FULL_LAT = 34'sd3600000000;
  localparam logic signed [ANG_W-1:0] FULL_DIFF = 34'sd7200000000;

  // odd part of both turn sizes and floor(2^54 / odd part)
  localparam logic signed [MUL_W-1:0] DIV_ODD = 34'sd3515625;
  localparam logic signed [MUL_W-1:0] RECIP_Q54 = 34'sd5124095576;

  // fixed-point constants
  localparam logic signed [MUL_W-1:0] TWO_PI_Q30 = 34'sd6746518852;
  localparam logic signed [CW-1:0] GAIN_INV_Q40 = 44'sd667681663043;
  localparam logic signed [MUL_W-1:0] EARTH_R_MM = 34'sd6371000000;
  localparam logic [DIST_W-1:0] MAX_DIST_MM = 35'd20015087000;
  localparam logic [60:0] ONE_Q60 = 61'd1 << 60;

  typedef logic signed [CW-1:0] atan_table_t [MAX_ITER];

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_LOAD, S_WRAP, S_FOLD, S_MUL, S_DIVINIT, S_DIV,
    S_QEST, S_QMUL, S_QFIX,
    S_CLOAD, S_CORDIC, S_CSTORE, S_M1, S_M2, S_M3, S_M4, S_M5, S_CLAMP,
    S_SQINIT, S_SQRT, S_VLOAD, S_D1, S_D2, S_D3, S_D4, S_DONE
  } state_t;

  // arctan(2^-s) in q62 by its alternating series
  function automatic logic signed [63:0] atan_recip_pow2_q62(input int s);
    logic [63:0] num;
    logic signed [63:0] sum;
    logic signed [63:0] t;
    num = 64'd1 << (62 - s);
    sum = '0;
    for (int k = 0; k < 32; k++) begin
      if (num != 0) begin
        t = $signed(num / 64'(2 * k + 1));
        if (k[0]) sum = sum - t;
        else sum = sum + t;
        num = num >> (2 * s);
      end
    end
    return sum;
  endfunction

  // arctan(1/3) in q62 by its alternating series
  function automatic logic signed [63:0] atan_recip3_q62();
    logic [63:0] num;
    logic signed [63:0] sum;
    logic signed [63:0] t;
    num = (64'd1 << 62) / 64'd3;
    sum = '0;
    for (int k = 0; k < 32; k++) begin
      if (num != 0) begin
        t = $signed(num / 64'(2 * k + 1));
        if (k[0]) sum = sum - t;
        else sum = sum + t;
        num = num / 64'd3 / 64'd3;
      end
    end
    return sum;
  endfunction

  // arctangent table in q40, entry zero is atan(1/2) + atan(1/3)
  function automatic atan_table_t build_atan_table();
    atan_table_t tab;
    logic signed [63:0] q62;
    for (int i = 0; i < MAX_ITER; i++) begin
      if (i == 0) q62 = atan_recip_pow2_q62(1) + atan_recip3_q62();
      else q62 = atan_recip_pow2_q62(i);
      tab[i] = CW'((q62 + 64'sd2097152) >>> 22);
    end
    return tab;
  endfunction

  localparam atan_table_t ATAN_TABLE = build_atan_table();

endpackage

// File: hw/rtl/track_step_haversine_distance.sv
// track_step_haversine_distance: great-circle distance between successive track points
//
// channel  | handshake                | word
// ---------+--------------------------+-------------------------------------
// point    | point_valid, point_stall | track_start, latitude, longitude
// dist     | dist_valid, dist_stall   | distance_mm
//
// A point with a previous one runs four sin/cos cordic runs (the turn divide is a
// reciprocal multiply with one correction), two square roots and one 32-step
// vectoring run, all through one cordic unit and one 34x34 multiplier. A first
// point skips these runs and goes straight to the output register.
// point_stall is high from accept until the result
// sits in the output register. A result waits in the output register while
// dist_stall is high; the block then holds its finished word and takes no new point.
// Synchronous reset clears the previous-point flag and empties the output register.
module track_step_haversine_distance
  import tshd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   point_valid,
  output logic                   point_stall,
  input  logic                   track_start,
  input  logic signed [30:0]     latitude,
  input  logic signed [31:0]     longitude,
  output logic                   dist_valid,
  input  logic                   dist_stall,
  output logic [DIST_W-1:0]      distance_mm
);

  state_t state, state_next;

  logic                    have_prev;
  logic signed [30:0]      prev_lat, cur_lat;
  logic signed [31:0]      prev_lon, cur_lon;
  logic                    skip;
  logic [1:0]              run;
  logic [CNT_W-1:0]        cnt;

  logic signed [ANG_W-1:0] ang;
  logic                    ang_neg, neg_cos;
  logic [52:0]             div_m;
  logic [30:0]             div_low;

  logic signed [CW-1:0]    cx, cy, cz;
  logic                    vec_mode;

  logic signed [Q_W-1:0]   sl, so, c1, c2, t_q, u_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [62:0]      a_acc;
  logic [60:0]             a_val;
  logic [60:0]             sq_v, sq_bit;
  logic [61:0]             sq_res;
  logic                    sq_second;
  logic [30:0]             r_val;
  logic [19:0]             frac_l;
  logic [56:0]             v_acc;
  logic [DIST_W-1:0]       dist_res;

  logic                    out_free;

  // turn size of the current run
  logic signed [ANG_W-1:0] full, half, quarter;
  assign full = run[1] ? FULL_LAT : FULL_DIFF;
  assign half = full >>> 1;
  assign quarter = full >>> 2;

  assign out_free = !dist_valid || !dist_stall;
  assign point_stall = (state != S_IDLE);

  // angle reduction into half a turn, then fold into a quarter
  logic signed [ANG_W-1:0] wrap_ang, fold_mag;
  logic                    fold_neg, fold_ncos;
  always_comb begin
    if (ang >= half) wrap_ang = ang - full;
    else if (ang < -half) wrap_ang = ang + full;
    else wrap_ang = ang;
    fold_ncos = 1'b0;
    if (ang > quarter) begin
      fold_mag = half - ang;
      fold_neg = 1'b0;
      fold_ncos = 1'b1;
    end else if (ang < -quarter) begin
      fold_mag = ang + half;
      fold_neg = 1'b1;
      fold_ncos = 1'b1;
    end else if (ang[ANG_W-1]) begin
      fold_mag = -ang;
      fold_neg = 1'b1;
    end else begin
      fold_mag = ang;
      fold_neg = 1'b0;
    end
  end

  // divide by the turn size: shift out its power of two, then reciprocal multiply
  logic [63:0] div_num;
  logic [52:0] q_rem;
  logic        q_fix;
  assign div_num = prod[63:0] + 64'($unsigned(half));
  assign q_rem = div_m - prod[52:0];
  assign q_fix = q_rem >= 53'($unsigned(DIV_ODD));

  // shared cordic step
  logic signed [CW-1:0] dx, dy, e_ang;
  logic                 pos;
  logic signed [CW-1:0] cx_step, cy_step, cz_step;
  always_comb begin
    dx = cy >>> cnt;
    dy = cx >>> cnt;
    e_ang = ATAN_TABLE[cnt];
    pos = vec_mode ? cy[CW-1] : !cz[CW-1];
    if (pos) begin
      cx_step = cx - dx;
      cy_step = cy + dy;
      cz_step = cz - e_ang;
    end else begin
      cx_step = cx + dx;
      cy_step = cy - dy;
      cz_step = cz + e_ang;
    end
  end

  // q40 to q30 rounding of the rotation results
  logic signed [CW-1:0]  cx_rnd, cy_rnd;
  logic signed [Q_W-1:0] s_q30, c_q30;
  assign cy_rnd = cy + 44'sd512;
  assign cx_rnd = cx + 44'sd512;
  assign s_q30 = Q_W'(cy_rnd >>> 10);
  assign c_q30 = neg_cos ? -Q_W'(cx_rnd >>> 10) : Q_W'(cx_rnd >>> 10);

  // digit-by-digit square root step
  logic [62:0] sq_try;
  logic        sq_ge;
  logic [61:0] sq_res_next;
  assign sq_try = {1'b0, sq_res} + {2'b0, sq_bit};
  assign sq_ge = {2'b0, sq_v} >= sq_try;
  assign sq_res_next = sq_ge ? (sq_res >> 1) + {1'b0, sq_bit} : sq_res >> 1;

  // clamped central angle split for the radius multiply
  logic [CW-2:0] theta;
  assign theta = cz[CW-1] ? '0 : cz[CW-2:0];

  // rounding to millimetres
  logic [56:0] mm_sum;
  logic [37:0] mm_val;
  assign mm_sum = v_acc + 57'd262144;
  assign mm_val = mm_sum[56:19];

  // shared multiplier operand select
  logic signed [MUL_W-1:0] mul_a, mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MUL: begin
        mul_a = ang;
        mul_b = TWO_PI_Q30;
      end
      S_DIV: begin
        mul_a = $signed({1'b0, div_m[52:20]});
        mul_b = RECIP_Q54;
      end
      S_QMUL: begin
        mul_a = $signed({3'b0, div_low});
        mul_b = DIV_ODD;
      end
      S_M1: begin
        mul_a = MUL_W'(so);
        mul_b = MUL_W'(c1);
      end
      S_M2: begin
        mul_a = MUL_W'(so);
        mul_b = MUL_W'(c2);
      end
      S_M3: begin
        mul_a = MUL_W'(sl);
        mul_b = MUL_W'(sl);
      end
      S_M4: begin
        mul_a = MUL_W'(t_q);
        mul_b = MUL_W'(u_q);
      end
      S_D1: begin
        mul_a = $signed({11'b0, theta[CW-2:20]});
        mul_b = EARTH_R_MM;
      end
      S_D2: begin
        mul_a = $signed({14'b0, frac_l});
        mul_b = EARTH_R_MM;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (point_valid) state_next = S_START;
      S_START:   state_next = skip ? S_DONE : S_LOAD;
      S_LOAD:    state_next = S_WRAP;
      S_WRAP:    state_next = S_FOLD;
      S_FOLD:    state_next = S_MUL;
      S_MUL:     state_next = S_DIVINIT;
      S_DIVINIT: state_next = S_DIV;
      S_DIV:     state_next = S_QEST;
      S_QEST:    state_next = S_QMUL;
      S_QMUL:    state_next = S_QFIX;
      S_QFIX:    state_next = S_CLOAD;
      S_CLOAD:   state_next = S_CORDIC;
      S_CORDIC: begin
        if (cnt == CNT_W'(CORDIC_STEPS - 1)) state_next = vec_mode ? S_D1 : S_CSTORE;
      end
      S_CSTORE:  state_next = (run == 2'd3) ? S_M1 : S_LOAD;
      S_M1:      state_next = S_M2;
      S_M2:      state_next = S_M3;
      S_M3:      state_next = S_M4;
      S_M4:      state_next = S_M5;
      S_M5:      state_next = S_CLAMP;
      S_CLAMP:   state_next = S_SQINIT;
      S_SQINIT:  state_next = S_SQRT;
      S_SQRT: begin
        if (cnt == CNT_W'(SQRT_STEPS - 1) && sq_second) state_next = S_VLOAD;
      end
      S_VLOAD:   state_next = S_CORDIC;
      S_D1:      state_next = S_D2;
      S_D2:      state_next = S_D3;
      S_D3:      state_next = S_D4;
      S_D4:      state_next = S_DONE;
      S_DONE:    if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev <= 1'b0;
      dist_valid <= 1'b0;
    end else begin
      if (!dist_stall) dist_valid <= 1'b0;
      if (state == S_DONE && out_free) begin
        dist_valid <= 1'b1;
        have_prev <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      S_IDLE: begin
        cur_lat <= latitude;
        cur_lon <= longitude;
        skip <= track_start || !have_prev;
      end
      S_START: run <= 2'd0;
      S_LOAD: begin
        case (run)
          2'd0:    ang <= ANG_W'(prev_lat) - ANG_W'(cur_lat);
          2'd1:    ang <= ANG_W'(prev_lon) - ANG_W'(cur_lon);
          2'd2:    ang <= ANG_W'(cur_lat);
          default: ang <= ANG_W'(prev_lat);
        endcase
      end
      S_WRAP: ang <= wrap_ang;
      S_FOLD: begin
        ang <= fold_mag;
        ang_neg <= fold_neg;
        neg_cos <= fold_ncos;
      end
      // latitude turn is 2^10 times the odd part, difference turn 2^11 times
      S_DIVINIT: div_m <= run[1] ? 53'(div_num >> 10) : 53'(div_num >> 11);
      // quotient estimate is at most one low
      S_QEST: div_low <= prod[64:34];
      S_QFIX: if (q_fix) div_low <= div_low + 1'b1;
      S_CLOAD: begin
        cx <= GAIN_INV_Q40;
        cy <= '0;
        cz <= ang_neg ? -$signed({2'b0, div_low, 10'b0}) : $signed({2'b0, div_low, 10'b0});
        vec_mode <= 1'b0;
        cnt <= '0;
      end
      S_CORDIC: begin
        cx <= cx_step;
        cy <= cy_step;
        cz <= cz_step;
        cnt <= cnt + 1'b1;
      end
      S_CSTORE: begin
        case (run)
          2'd0:    sl <= s_q30;
          2'd1:    so <= s_q30;
          2'd2:    c1 <= c_q30;
          default: c2 <= c_q30;
        endcase
        run <= run + 1'b1;
      end
      S_M2: t_q <= Q_W'((prod + 68'sd536870912) >>> 30);
      S_M3: u_q <= Q_W'((prod + 68'sd536870912) >>> 30);
      S_M4: a_acc <= 63'(prod);
      S_M5: a_acc <= a_acc + 63'(prod);
      S_CLAMP: begin
        if (a_acc[62]) a_val <= '0;
        else if (a_acc > $signed({2'b0, ONE_Q60})) a_val <= ONE_Q60;
        else a_val <= a_acc[60:0];
      end
      S_SQINIT: begin
        sq_v <= a_val;
        sq_res <= '0;
        sq_bit <= ONE_Q60;
        sq_second <= 1'b0;
        cnt <= '0;
      end
      S_SQRT: begin
        if (cnt == CNT_W'(SQRT_STEPS - 1)) begin
          // first pass gives sqrt(a), second sqrt(1 - a)
          if (!sq_second) begin
            r_val <= sq_res_next[30:0];
            sq_v <= ONE_Q60 - a_val;
            sq_res <= '0;
            sq_bit <= ONE_Q60;
            sq_second <= 1'b1;
            cnt <= '0;
          end else begin
            cx <= $signed({3'b0, sq_res_next[30:0], 10'b0});
            cnt <= '0;
          end
        end else begin
          if (sq_ge) sq_v <= sq_v - sq_try[60:0];
          sq_res <= sq_res_next;
          sq_bit <= sq_bit >> 2;
          cnt <= cnt + 1'b1;
        end
      end
      S_VLOAD: begin
        cy <= $signed({3'b0, r_val, 10'b0});
        cz <= '0;
        vec_mode <= 1'b1;
        cnt <= '0;
      end
      S_D1: frac_l <= theta[19:0];
      S_D2: v_acc <= prod[56:0];
      S_D3: v_acc <= v_acc + 57'(prod[PROD_W-1:20]);
      S_D4: dist_res <= (mm_val > 38'(MAX_DIST_MM)) ? MAX_DIST_MM : mm_val[DIST_W-1:0];
      S_DONE: begin
        if (out_free) begin
          distance_mm <= skip ? '0 : dist_res;
          prev_lat <= cur_lat;
          prev_lon <= cur_lon;
        end
      end
      default: begin
      end
    endcase
  end

  // an accepted word always starts a new computation
  assert property (@(posedge clk) disable iff (rst)
    (point_valid && !point_stall) |=> state == S_START)
    else $error("accepted point did not start the sequencer");

  // a first point of a track yields zero
  assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && skip && out_free) |=> (dist_valid && distance_mm == '0))
    else $error("first point gave a nonzero distance");

  // distances never pass half the circumference
  assert property (@(posedge clk) disable iff (rst)
    dist_valid |-> distance_mm <= MAX_DIST_MM)
    else $error("distance above saturation limit");

endmodule

// File: tb/sv/tb.sv
// tb: self-checking bench for the track-step haversine distance block
module tb
  import tshd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM = 1350;
  localparam int N_TURNS = 32;
  localparam longint unsigned RAD_PER_TURN_Q30 = 64'd6746518852;
  localparam longint GAIN_Q40 = 64'sd667681663043;
  localparam longint RADIUS_MM = 64'sd6371000000;
  localparam longint SAT_MM = 64'sd20015087000;
  localparam longint UNIT_Q60 = 64'sd1 << 60;
  localparam longint LAT_TURN = 64'sd3600000000;
  localparam longint DIFF_TURN = 64'sd7200000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic point_valid = 1'b0;
  logic point_stall;
  logic track_start = 1'b0;
  logic signed [30:0] latitude = '0;
  logic signed [31:0] longitude = '0;
  logic dist_valid;
  logic dist_stall = 1'b0;
  logic [DIST_W-1:0] distance_mm;

  track_step_haversine_distance i_dut (
    .clk(clk), .rst(rst),
    .point_valid(point_valid), .point_stall(point_stall),
    .track_start(track_start), .latitude(latitude), .longitude(longitude),
    .dist_valid(dist_valid), .dist_stall(dist_stall), .distance_mm(distance_mm)
  );

  always #5 clk = ~clk;

  // arctangent steps in q40, own copy
  longint atan_step [40];
  // track state of the predictor
  longint last_lat, last_lon;
  bit have_last;
  // distances waiting for the block
  longint unsigned dist_pending [$];
  int errors = 0;
  int words_checked = 0;
  int points_sent = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  function automatic longint arctan_recip(longint unsigned n);
    longint unsigned num;
    longint unsigned k;
    longint sum;
    num = (64'd1 << 62) / n;
    k = 0;
    sum = 0;
    while (num != 0) begin
      if (k[0]) sum = sum - longint'(num / (2 * k + 1));
      else sum = sum + longint'(num / (2 * k + 1));
      num = num / n / n;
      k++;
    end
    return sum;
  endfunction

  initial begin
    longint q;
    for (int i = 0; i < 40; i++) begin
      q = (i == 0) ? arctan_recip(2) + arctan_recip(3) : arctan_recip(64'd1 << i);
      atan_step[i] = (q + (64'sd1 << 21)) >>> 22;
    end
  end

  // rotation cordic: sine and cosine in q30 of an angle in 1e-7 degree units
  task automatic rotate(input longint ang, input longint turn, output longint s,
                        output longint c);
    longint half, quarter, x, y, z, dx, dy;
    longint unsigned mag;
    bit flip;
    half = turn / 2;
    quarter = turn / 4;
    flip = 1'b0;
    ang = ang % turn;
    if (ang >= half) ang -= turn;
    if (ang < -half) ang += turn;
    if (ang > quarter) begin
      ang = half - ang;
      flip = 1'b1;
    end else if (ang < -quarter) begin
      ang = -half - ang;
      flip = 1'b1;
    end
    mag = (ang < 0) ? longint'(-ang) : ang;
    z = longint'((mag * RAD_PER_TURN_Q30 + longint'(half)) / longint'(turn)) * 1024;
    if (ang < 0) z = -z;
    x = GAIN_Q40;
    y = 0;
    for (int i = 0; i < N_TURNS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_step[i];
      end else begin
        x += dx; y -= dy; z += atan_step[i];
      end
    end
    s = (y + 512) >>> 10;
    c = (x + 512) >>> 10;
    if (flip) c = -c;
  endtask

  // vectoring cordic: angle in q40
  function automatic longint vector_angle(longint x30, longint y30);
    longint x, y, z, dx, dy;
    x = x30 * 1024;
    y = y30 * 1024;
    z = 0;
    for (int i = 0; i < N_TURNS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += atan_step[i];
      end else begin
        x -= dx; y += dy; z -= atan_step[i];
      end
    end
    return z;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  task automatic great_circle_mm(input longint la1, input longint lo1, input longint la2,
                                 input longint lo2, output longint unsigned mm);
    longint sl, so, c1, c2, dummy, t, u, a, r, w, th;
    longint unsigned h, l, v;
    rotate(la2 - la1, DIFF_TURN, sl, dummy);
    rotate(lo2 - lo1, DIFF_TURN, so, dummy);
    rotate(la1, LAT_TURN, dummy, c1);
    rotate(la2, LAT_TURN, dummy, c2);
    t = (so * c1 + (64'sd1 << 29)) >>> 30;
    u = (so * c2 + (64'sd1 << 29)) >>> 30;
    a = sl * sl + t * u;
    if (a < 0) a = 0;
    if (a > UNIT_Q60) a = UNIT_Q60;
    r = floor_sqrt(a);
    w = floor_sqrt(UNIT_Q60 - a);
    th = vector_angle(w, r);
    if (th < 0) th = 0;
    h = th >> 20;
    l = th & 64'hFFFFF;
    v = h * RADIUS_MM + ((l * RADIUS_MM) >> 20);
    mm = (v + (64'd1 << 18)) >> 19;
    if (mm > SAT_MM) mm = SAT_MM;
  endtask

  // accepted point: advance the predictor
  task automatic predict_step(input bit st, input longint la, input longint lo);
    longint unsigned d;
    d = 0;
    if (!st && have_last) great_circle_mm(la, lo, last_lat, last_lon, d);
    last_lat = la;
    last_lon = lo;
    have_last = 1'b1;
    dist_pending.insert(dist_pending.size(), d & ((64'd1 << 35) - 1));
  endtask

  task automatic report_mismatch(input string msg);
    errors++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // accept and compare on the rising edge
  always @(posedge clk) begin
    if (!rst && point_valid && !point_stall)
      predict_step(track_start, longint'(latitude), longint'(longitude));
    if (!rst && dist_valid && !dist_stall) begin
      words_checked++;
      if (dist_pending.size() == 0) report_mismatch("distance word with none expected");
      else begin
        longint unsigned e;
        e = dist_pending.pop_front();
        if (distance_mm !== e[34:0])
          report_mismatch($sformatf("distance_mm got %0d want %0d", distance_mm, e));
      end
    end
  end

  // receiver stalls: random, quiet stretch, one long hold
  initial begin
    int hold;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        hold = 0;
        while (hold < 3000) begin
          dist_stall <= 1'b1;
          @(negedge clk);
          hold++;
        end
      end
      dist_stall <= (!quiet && $urandom_range(99) < 15);
      @(negedge clk);
    end
  end

  typedef struct {
    bit st;
    longint la;
    longint lo;
    bit known;
    longint unsigned want;
  } point_row_t;

  point_row_t rows [$];

  // put one word on the point channel and wait for acceptance
  task automatic send_point(input bit st, input longint la, input longint lo);
    while (!quiet && $urandom_range(99) < 15) begin
      point_valid <= 1'b0;
      @(negedge clk);
    end
    point_valid <= 1'b1;
    track_start <= st;
    latitude <= la[30:0];
    longitude <= lo[31:0];
    @(posedge clk);
    while (point_stall) @(posedge clk);
    points_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    point_valid <= 1'b0;
    while (dist_pending.size() != 0) @(negedge clk);
  endtask

  initial begin
    longint la, lo, pla, plo;
    bit st;
    int kind, seq_left;
    have_last = 1'b0;
    last_lat = 0;
    last_lon = 0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // directed table: zero rows are first points
    rows = '{
      '{0, 0, 0, 1, 0},
      '{0, 900000000, 1800000000, 0, 0},
      '{0, -900000000, -1800000000, 0, 0},
      '{1, 0, 0, 1, 0},
      '{0, 0, 0, 0, 0},
      '{0, 0, 1800000000, 0, 0},
      '{0, 0, -1800000000, 0, 0},
      '{0, 1, 1, 0, 0},
      '{1, 0, 1799999999, 1, 0},
      '{0, 0, -1799999999, 0, 0},
      '{0, 900000000, 0, 0, 0},
      '{0, -900000000, 0, 0, 0},
      '{0, -1073741824, -2147483648, 0, 0},
      '{0, 1073741823, 2147483647, 0, 0},
      '{1, 450000000, 900000000, 1, 0},
      '{0, 450000010, 900000010, 0, 0},
      '{0, -450000000, -900000000, 0, 0}
    };
    foreach (rows[i]) begin
      if (rows[i].known) begin
        drain();
        send_point(rows[i].st, rows[i].la, rows[i].lo);
        // the typed value must agree with the predictor before the block is heard
        if (dist_pending[$] != rows[i].want) report_mismatch("directed row disagrees");
      end else send_point(rows[i].st, rows[i].la, rows[i].lo);
    end
    drain();

    // random tracks of nearby points, with restarts and some raw noise
    pla = 0;
    plo = 0;
    seq_left = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      quiet = (n >= 400 && n < 550);
      if (n == 250) hold_req = 1'b1;
      if (n == 700) drain();
      kind = $urandom_range(99);
      st = 1'b0;
      if (kind < 10) begin
        la = longint'($signed($urandom())) >>> 1;
        lo = longint'($signed($urandom()));
        st = 1'($urandom_range(1));
      end else if (seq_left == 0 || kind < 15) begin
        seq_left = $urandom_range(40, 5);
        la = longint'($urandom_range(1800000000)) - 900000000;
        lo = longint'($urandom_range(2000000000)) + longint'($urandom_range(1600000000))
             - 1800000000;
        st = kind[0];
      end else begin
        seq_left--;
        la = pla + longint'($urandom_range(200000)) - 100000;
        lo = plo + longint'($urandom_range(($urandom_range(3) == 0) ? 60000000 : 200000))
             - longint'($urandom_range(100000));
        if (la > 900000000) la = 900000000;
        if (la < -900000000) la = -900000000;
        if (lo > 1800000000) lo -= 3600000000;
        if (lo < -1800000000) lo += 3600000000;
      end
      pla = la;
      plo = lo;
      send_point(st, la, lo);
    end
    quiet = 1'b0;
    drain();
    repeat (500) @(negedge clk);

    $display("covered %0d points and %0d distance words, incl. poles, antipodes,",
             points_sent, words_checked);
    $display("dateline, raw out-of-range words, a long receiver hold and a drained pause");
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #60ms;
    $display("timeout with %0d distances outstanding", dist_pending.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
